// ----- hw/rtl/rg32_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rg32_pkg
// shared types, constants and the belt-mill round function
// ----------------------------------------------------------------------------
package rg32_pkg;

    localparam int MILL_LEN  = 19;
    localparam int BELT_COLS = 13;
    localparam int BELT_ROWS = 3;

    // absorbed words land in mill[MILL_ABS_BASE + slot]
    localparam logic [4:0] MILL_ABS_BASE = 5'd16;
    localparam logic [1:0] SLOT_LAST     = 2'd2;
    localparam logic [4:0] BLANK_LAST    = 5'd16;
    localparam logic [6:0] OUT_WORDS_RST = 7'd8;
    localparam logic [6:0] OUT_WORDS_MAX = 7'd64;

    typedef logic [MILL_LEN-1:0][31:0]                   t_mill;
    typedef logic [BELT_ROWS-1:0][BELT_COLS-1:0][31:0]   t_belt;

    typedef struct packed {
        t_mill mill;
        t_belt belt;
    } t_bm;

    typedef enum logic [1:0] {
        OP_ABSORB     = 2'd0,
        OP_FINAL_FULL = 2'd1,
        OP_FINAL_PART = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] word;
    } t_item;

    function automatic t_bm rg32_round(input t_mill m_in, input t_belt b_in);
        t_belt                 b;
        t_mill                 t;
        t_mill                 m;
        logic [31:0]           x;
        logic [BELT_ROWS-1:0][31:0] carry;
        int                    rot;
        int                    y;
        t_bm                   res;
        b = b_in;
        // feedforward from mill
        for (int i = 0; i < 12; i++) begin
            b[i % BELT_ROWS][i] = b[i % BELT_ROWS][i] ^ m_in[i + 1];
        end
        // rotate each row by one column
        for (int r = 0; r < BELT_ROWS; r++) begin
            carry[r] = b[r][BELT_COLS-1];
            for (int c = BELT_COLS - 1; c > 0; c--) begin
                b[r][c] = b[r][c-1];
            end
            b[r][0] = carry[r];
        end
        // gamma, pi, rho
        rot = 0;
        for (int i = 0; i < MILL_LEN; i++) begin
            y    = (i * 7) % MILL_LEN;
            x    = m_in[y] ^ (m_in[(y + 1) % MILL_LEN] | ~m_in[(y + 2) % MILL_LEN]);
            rot  = (rot + i) % 32;
            t[i] = (x >> rot) | (x << ((32 - rot) % 32));
        end
        // theta
        for (int i = 0; i < MILL_LEN; i++) begin
            m[i] = t[i] ^ t[(i + 1) % MILL_LEN] ^ t[(i + 4) % MILL_LEN];
        end
        // belt to mill, iota
        for (int r = 0; r < BELT_ROWS; r++) begin
            m[13 + r] = m[13 + r] ^ carry[r];
        end
        m[0] = m[0] ^ 32'd1;
        res.mill = m;
        res.belt = b;
        return res;
    endfunction

endpackage

// ----- hw/rtl/rg32_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rg32_front
// accepts message words, works out the padded final word, queues operations
// ----------------------------------------------------------------------------
module rg32_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [39:0]    s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero
    input  logic           s_axis_tlast,
    output rg32_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);
    import rg32_pkg::*;

    t_item       r_q [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    t_item       w_item;
    logic        w_push, w_pop;
    logic [31:0] w_data;
    logic [2:0]  w_cnt;

    assign w_data = s_axis_tdata[31:0];
    assign w_cnt  = s_axis_tdata[34:32];

    always_comb begin
        w_item.op   = OP_ABSORB;
        w_item.word = w_data;
        if (s_axis_tlast) begin
            if (w_cnt inside {[3'd4:3'd7]}) begin
                w_item.op = OP_FINAL_FULL;
            end else begin
                w_item.op = OP_FINAL_PART;
                case (w_cnt)
                    3'd0:    w_item.word = 32'h0000_0001;
                    3'd1:    w_item.word = {23'd0, 1'b1, w_data[7:0]};
                    3'd2:    w_item.word = {15'd0, 1'b1, w_data[15:0]};
                    3'd3:    w_item.word = {7'd0, 1'b1, w_data[23:0]};
                    default: w_item.word = w_data;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_count != 2'd0);
    assign w_pop         = o_item_valid && i_item_pop;
    assign o_item        = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/rg32_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rg32_back
// belt-mill state, round sequencer and digest output register
// ----------------------------------------------------------------------------
module rg32_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rg32_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_pop,
    input  logic [5:0]      i_last_idx,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [39:0]     m_axis_tdata,   // digest_word[31:0], word_index[37:32], zero
    output logic            m_axis_tlast
);
    import rg32_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_PAD   = 5'b00100,
        S_BLANK = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_mill       r_mill, n_mill;
    t_belt       r_belt, n_belt;
    logic [1:0]  r_slot, n_slot;
    logic        r_pad_pend, n_pad_pend;
    logic        r_half, n_half;
    logic [4:0]  r_cnt, n_cnt;
    logic [5:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [5:0]  r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last;
    t_bm         w_rnd;
    logic        w_load;
    logic        w_load_last;

    assign w_rnd       = rg32_round(r_mill, r_belt);
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign w_load_last = w_load && (r_idx == i_last_idx);
    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid;

    always_comb begin
        logic [1:0] s_next;
        n_state     = r_state;
        n_mill      = r_mill;
        n_belt      = r_belt;
        n_slot      = r_slot;
        n_pad_pend  = r_pad_pend;
        n_half      = r_half;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        s_next      = r_slot + 2'd1;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_belt[r_slot][0] = r_belt[r_slot][0] ^ i_item.word;
                    n_mill[MILL_ABS_BASE + 5'(r_slot)] =
                        r_mill[MILL_ABS_BASE + 5'(r_slot)] ^ i_item.word;
                    n_cnt = 5'd0;
                    case (i_item.op)
                        OP_ABSORB: begin
                            if (r_slot == SLOT_LAST) begin
                                n_slot     = 2'd0;
                                n_pad_pend = 1'b0;
                                n_state    = S_ROUND;
                            end else begin
                                n_slot = s_next;
                            end
                        end
                        OP_FINAL_FULL: begin
                            if (r_slot == SLOT_LAST) begin
                                n_slot     = 2'd0;
                                n_pad_pend = 1'b1;
                                n_state    = S_ROUND;
                            end else begin
                                // pad byte goes straight into the next slot
                                n_belt[s_next][0] = r_belt[s_next][0] ^ 32'd1;
                                n_mill[MILL_ABS_BASE + 5'(s_next)] =
                                    r_mill[MILL_ABS_BASE + 5'(s_next)] ^ 32'd1;
                                n_state = S_BLANK;
                            end
                        end
                        default: begin
                            n_state = S_BLANK;
                        end
                    endcase
                end
            end
            S_ROUND: begin
                n_mill  = w_rnd.mill;
                n_belt  = w_rnd.belt;
                n_state = r_pad_pend ? S_PAD : S_IDLE;
            end
            S_PAD: begin
                n_belt[r_slot][0] = r_belt[r_slot][0] ^ 32'd1;
                n_mill[MILL_ABS_BASE + 5'(r_slot)] =
                    r_mill[MILL_ABS_BASE + 5'(r_slot)] ^ 32'd1;
                n_cnt   = 5'd0;
                n_state = S_BLANK;
            end
            S_BLANK: begin
                n_mill = w_rnd.mill;
                n_belt = w_rnd.belt;
                if (r_cnt == BLANK_LAST) begin
                    n_half  = 1'b0;
                    n_idx   = 6'd0;
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_last  = w_load_last;
                    if (!r_half) begin
                        n_mill     = w_rnd.mill;
                        n_belt     = w_rnd.belt;
                        n_out_word = w_rnd.mill[1];
                    end else begin
                        n_out_word = r_mill[2];
                    end
                    n_half = ~r_half;
                    n_idx  = r_idx + 6'd1;
                    if (w_load_last) begin
                        // digest done: back to a blank state
                        n_mill     = '0;
                        n_belt     = '0;
                        n_slot     = 2'd0;
                        n_half     = 1'b0;
                        n_pad_pend = 1'b0;
                        n_idx      = 6'd0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mill      <= '0;
            r_belt      <= '0;
            r_slot      <= 2'd0;
            r_pad_pend  <= 1'b0;
            r_half      <= 1'b0;
            r_cnt       <= 5'd0;
            r_idx       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mill      <= n_mill;
            r_belt      <= n_belt;
            r_slot      <= n_slot;
            r_pad_pend  <= n_pad_pend;
            r_half      <= n_half;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'd0, r_out_idx, r_out_word};
    assign m_axis_tlast  = r_out_last;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> (r_state == S_IDLE))
        else $error("queue popped outside idle");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("word slot out of range");

    a_blank_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLANK) |-> (r_cnt <= BLANK_LAST))
        else $error("blank round count overrun");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_last |=> (r_state == S_IDLE) && (r_slot == 2'd0) && !r_half)
        else $error("state not cleared after final digest word");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten");

endmodule

// ----- hw/rtl/radiogatun32_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiogatun32_hash
// radiogatun[32] hash engine with streaming input, digest output and a
// digest length register
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                         word contents
//  s_axis    in         tvalid tready tdata[39:0] tlast data_word, byte_count
//  m_axis    out        tvalid tready tdata[39:0] tlast digest_word, word_index
//  cfg       in         valid ready data[6:0]           output_words
//
// back end: a message word is absorbed in the idle state; one that
//   closes a group of three then runs the belt-mill round in its own state
// the final word is padded (a round first if a full word closes a group),
//   then 17 rounds run, then one digest word per cycle while the sink keeps up
// the front queue holds two words, so input is taken while the back end runs
//   rounds or waits on the sink; s_axis_tready drops only when it is full
// reset (synchronous, active low) clears mill, belt and control; output_words
//   returns to 8; no clearing pass
// cfg is always ready; write it only while the engine is idle
//
module radiogatun32_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[37:32], zero
    output logic        m_axis_tlast,   // final_word
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // output_words
);
    import rg32_pkg::*;

    logic [6:0] r_out_words;
    logic [5:0] w_last_idx;
    t_item      w_item;
    logic       w_item_valid;
    logic       w_item_pop;

    // digest length register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_words <= OUT_WORDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_out_words <= i_cfg_data;
        end
    end

    // index of the last digest word: zero counts as one, above 64 as 64
    always_comb begin
        if (r_out_words == 7'd0) begin
            w_last_idx = 6'd0;
        end else if (r_out_words > OUT_WORDS_MAX) begin
            w_last_idx = 6'd63;
        end else begin
            w_last_idx = 6'(r_out_words - 7'd1);
        end
    end

    // front: classify and pad, two-entry queue
    rg32_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    // back: absorb, rounds, squeeze
    rg32_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_item_pop    (w_item_pop),
        .i_last_idx    (w_last_idx),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- bench/radiogatun32_hash_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiogatun32_hash_tb
// self-checking bench for the radiogatun[32] engine: a directed table walks
// the padding cases and the digest length extremes, then random messages run
// under three idling mixes; every digest word is compared with a predictor
// ----------------------------------------------------------------------------
module radiogatun32_hash_tb;

    localparam int MILL_N         = 19;
    localparam int BELT_N         = 13;
    localparam int FINAL_ROUNDS   = 17;      // final round plus 16 blank ones
    localparam int DIGEST_MAX     = 64;
    localparam int DRAIN_CYCLES   = 48;      // padding and 17 rounds, with slack
    localparam int SINK_HOLD      = 400;     // long sink stall for back-pressure
    localparam int LIMIT_CYCLES   = 400000;
    localparam int ITEMS_PER_MIX  = 40;

    // one row of the directed table: a message word or a digest length write
    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] data;      // message word, or the digest length to write
        logic [2:0]  count;
        logic        last;
    } t_row;

    // one expected digest word
    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  index;
        logic        final_flag;
    } t_digest;

    localparam int ROW_N = 25;
    localparam t_row STIM_ROWS [0:ROW_N-1] = '{
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1},  // empty message, pad only
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd1, 1'b1},  // bytes above the count masked
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd2, 1'b1},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd3, 1'b1},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd4, 1'b1},  // full last word, pad word follows
        '{ROW_WORD, 32'h0123_4567, 3'd5, 1'b0},  // count ignored when not last
        '{ROW_WORD, 32'h89AB_CDEF, 3'd0, 1'b0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd5, 1'b1},  // full last word closes a group
        '{ROW_WORD, 32'hA5A5_A5A5, 3'd0, 1'b0},
        '{ROW_WORD, 32'h5A5A_5A5A, 3'd7, 1'b0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd0, 1'b1},  // partial last right after a round
        '{ROW_WORD, 32'h3C69_0F1E, 3'd0, 1'b0},
        '{ROW_WORD, 32'hC3A5_F00D, 3'd6, 1'b1},  // count above four, slot one
        '{ROW_CFG,  32'd1,         3'd0, 1'b0},  // shortest digest
        '{ROW_WORD, 32'h8000_0001, 3'd2, 1'b1},
        '{ROW_CFG,  32'd0,         3'd0, 1'b0},  // zero acts as one
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1},
        '{ROW_CFG,  32'd64,        3'd0, 1'b0},  // longest digest
        '{ROW_WORD, 32'h1357_9BDF, 3'd0, 1'b0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd1, 1'b1},
        '{ROW_CFG,  32'd127,       3'd0, 1'b0},  // above range clamps to 64
        '{ROW_WORD, 32'h0000_0000, 3'd4, 1'b1},
        '{ROW_CFG,  32'd3,         3'd0, 1'b0},  // odd length, half pair at end
        '{ROW_WORD, 32'h7FFF_FFFF, 3'd3, 1'b1}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata   = '0;   // data_word[31:0], byte_count[34:32], zero
    logic        s_axis_tlast   = 1'b0; // last
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [39:0] m_axis_tdata;          // digest_word[31:0], word_index[37:32], zero
    logic        m_axis_tlast;          // final_word
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data     = '0;   // output_words

    // predictor state
    logic [31:0] pm [0:MILL_N-1];
    logic [31:0] pb [0:2][0:BELT_N-1];
    logic [1:0]  msg_slot;
    logic        digest_half;
    logic [6:0]  digest_len;

    t_digest     digest_q [$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req_cnt  = 0;
    int          hold_done_cnt = 0;
    int          hold_left     = 0;

    radiogatun32_hash u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_hash_state();
        for (int i = 0; i < MILL_N; i++) pm[i] = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < BELT_N; c++) pb[r][c] = '0;
        msg_slot    = '0;
        digest_half = 1'b0;
    endfunction

    function automatic void beltmill_step();
        logic [31:0] t [0:MILL_N-1];
        logic [31:0] carry [0:2];
        logic [63:0] twice;
        int          y;
        int          rot;
        // feedforward: mill words 1..12 into the belt diagonal
        for (int i = 0; i < 12; i++) pb[i % 3][i] ^= pm[i + 1];
        // each belt row shifts by one column, the top word wraps around
        for (int r = 0; r < 3; r++) begin
            carry[r] = pb[r][BELT_N-1];
            for (int c = BELT_N - 1; c > 0; c--) pb[r][c] = pb[r][c-1];
            pb[r][0] = carry[r];
        end
        // nonlinear step, word permutation and growing rotate right
        rot = 0;
        for (int i = 0; i < MILL_N; i++) begin
            y     = (i * 7) % MILL_N;
            rot   = (rot + i) % 32;
            twice = {2{pm[y] ^ (pm[(y + 1) % MILL_N] | ~pm[(y + 2) % MILL_N])}};
            t[i]  = twice[rot +: 32];
        end
        for (int i = 0; i < MILL_N; i++)
            pm[i] = t[i] ^ t[(i + 1) % MILL_N] ^ t[(i + 4) % MILL_N];
        for (int r = 0; r < 3; r++) pm[13 + r] ^= carry[r];
        pm[0] ^= 32'd1;
    endfunction

    function automatic void inject_word(input logic [31:0] w);
        pb[msg_slot][0]   ^= w;
        pm[16 + msg_slot] ^= w;
    endfunction

    function automatic void absorb_msg_word(input logic [31:0] w);
        inject_word(w);
        if (msg_slot == 2'd2) begin
            beltmill_step();
            msg_slot = '0;
        end else begin
            msg_slot = msg_slot + 2'd1;
        end
    endfunction

    // one accepted input word; a last word queues the whole digest
    function automatic void predict_digest(input logic [31:0] data,
                                           input logic [2:0] count, input logic last);
        logic [31:0] pad_word;
        logic [31:0] w;
        int          n;
        int          bits;
        t_digest     e;
        if (!last) begin
            absorb_msg_word(data);
            return;
        end
        if (count >= 3'd4) begin
            absorb_msg_word(data);
            pad_word = 32'd1;
        end else begin
            bits     = 8 * count;
            pad_word = (data & ((32'd1 << bits) - 32'd1)) | (32'd1 << bits);
        end
        inject_word(pad_word);
        for (int k = 0; k < FINAL_ROUNDS; k++) beltmill_step();
        n = (digest_len == 0) ? 1 : (digest_len > DIGEST_MAX) ? DIGEST_MAX : digest_len;
        for (int k = 0; k < n; k++) begin
            if (!digest_half) begin
                beltmill_step();
                w           = pm[1];
                digest_half = 1'b1;
            end else begin
                w           = pm[2];
                digest_half = 1'b0;
            end
            e.word       = w;
            e.index      = k[5:0];
            e.final_flag = (k + 1 == n);
            digest_q.push_back(e);
        end
        clear_hash_state();
    endfunction

    // ------------------------------------------------------------------------
    // monitor: config writes, accepted message words, digest word check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_digest e;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) digest_len = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h with no expected word pending", m_axis_tdata[31:0]);
                    fail_count++;
                end else begin
                    e = digest_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.word) begin
                        $error("digest_word expected %h actual %h", e.word, m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[37:32] !== e.index) begin
                        $error("word_index expected %0d actual %0d", e.index,
                               m_axis_tdata[37:32]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== e.final_flag) begin
                        $error("final_word expected %b actual %b", e.final_flag, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_digest(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // sink: random stalls, plus a long hold when the stimulus asks for one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt <= hold_done_cnt + 1;
            hold_left     <= SINK_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("radiogatun32_hash verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // offer one message word, with an occasional gap first
    task automatic send_msg_word(input logic [31:0] data, input logic [2:0] count,
                                 input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, count, data};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // engine idle: every digest word back, then the round pipeline settled
    task automatic wait_engine_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_digest_len(input logic [6:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_msg_data();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 32'h0000_0000;
        if (pick == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // random messages until about n_items words have gone in
    task automatic send_random_messages(input int n_items);
        int sent;
        int body;
        sent = 0;
        while (sent < n_items) begin
            // mostly short messages, now and then a longer one
            body = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
            for (int k = 0; k < body; k++)
                send_msg_word(rand_msg_data(), 3'($urandom_range(7)), 1'b0);
            send_msg_word(rand_msg_data(), 3'($urandom_range(7)), 1'b1);
            sent += body + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        clear_hash_state();
        digest_len = 7'd8;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, first idling mix
        send_idle_pct = 23;
        recv_idle_pct = 46;
        for (int r = 0; r < ROW_N; r++) begin
            if (STIM_ROWS[r].kind == ROW_CFG) begin
                wait_engine_idle();
                write_digest_len(STIM_ROWS[r].data[6:0]);
            end else begin
                send_msg_word(STIM_ROWS[r].data, STIM_ROWS[r].count, STIM_ROWS[r].last);
            end
        end

        // back-pressure: sink held off while messages keep coming
        wait_engine_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_digest_len(7'd12);
        hold_req_cnt <= hold_req_cnt + 1;
        for (int m = 0; m < 4; m++) begin
            send_msg_word($urandom, 3'd0, 1'b0);
            send_msg_word($urandom, 3'd0, 1'b0);
            send_msg_word($urandom, 3'($urandom_range(7)), 1'b1);
        end

        // random messages under three idling mixes
        for (int mix = 0; mix < 3; mix++) begin
            wait_engine_idle();
            send_idle_pct = (mix == 0) ? 23 : (mix == 1) ? 46 : 0;
            recv_idle_pct = (mix == 0) ? 46 : (mix == 1) ? 23 : 0;
            write_digest_len(7'($urandom_range(1, 20)));
            send_random_messages(ITEMS_PER_MIX);
        end

        wait_engine_idle();
        if (digest_q.size() != 0) begin
            $error("%0d expected digest words never arrived", digest_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("radiogatun32_hash verification clean");
        end else begin
            $display("radiogatun32_hash verification failed");
        end
        $finish;
    end

endmodule
